// File: rtl/core/flt_pkg.sv
package flt_pkg;

  localparam int ADDR_W           = 32;
  localparam int FAIL_W           = 4;
  localparam int STATUS_W         = 4;
  localparam int THR_W            = 4;
  localparam int DEF_TABLE_ENTRIES = 64;

  localparam logic [THR_W-1:0]  SUSP_THR_RESET  = 4'd5;
  localparam logic [THR_W-1:0]  BLOCK_THR_RESET = 4'd10;
  localparam logic [FAIL_W-1:0] FAIL_MAX        = 4'd15;

  // request kinds
  localparam logic KIND_LOGIN = 1'b0;
  localparam logic KIND_LIST  = 1'b1;

  // register index (paddr[2])
  localparam logic REG_SUSP_THR  = 1'b0;
  localparam logic REG_BLOCK_THR = 1'b1;

  // result status codes
  localparam logic [STATUS_W-1:0] ST_SUCCESS     = 4'd0;
  localparam logic [STATUS_W-1:0] ST_FAILED      = 4'd1;
  localparam logic [STATUS_W-1:0] ST_SUSPICIOUS  = 4'd2;
  localparam logic [STATUS_W-1:0] ST_NOW_BLOCKED = 4'd3;
  localparam logic [STATUS_W-1:0] ST_REFUSED     = 4'd4;
  localparam logic [STATUS_W-1:0] ST_FULL        = 4'd5;
  localparam logic [STATUS_W-1:0] ST_LISTED      = 4'd6;
  localparam logic [STATUS_W-1:0] ST_NONE        = 4'd7;
  localparam logic [STATUS_W-1:0] ST_DENIED      = 4'd8;

  typedef struct packed {
    logic [ADDR_W-1:0] addr;
    logic [FAIL_W-1:0] fail;
    logic              blk;
  } entry_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_UPDATE,
    S_EMIT
  } state_t;

endpackage

// File: rtl/core/failed_login_lockout_table.sv
// A login is answered after a table scan, one stored entry compared per cycle through
//   the single registered read port, then the entry update (when there is room) and the result.
// One request at a time; a list request scans the table, waiting whenever the result side
//   stalls, and emits one result per blocked entry.
// Reset (rst, synchronous, active high): table empty, thresholds 5 and 10,
//   no result pending. Table memory itself is not cleared; entries past the count are unused.
module failed_login_lockout_table
  import flt_pkg::*;
#(
  parameter int TABLE_ENTRIES = DEF_TABLE_ENTRIES
) (
  input  logic        clk,
  input  logic        rst,
  // request stream
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [39:0] s_tdata,   // [31:0] source_addr, [32] credentials_valid,
                                 // [33] requester_is_admin, [39:34] zero
  input  logic [0:0]  s_tuser,   // [0] kind
  // result stream
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // [31:0] listed_addr
  output logic [3:0]  m_tuser,   // [3:0] status
  output logic        m_tlast,   // last
  // configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int IDX_W = $clog2(TABLE_ENTRIES);
  localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);

  // ---------------- configuration registers ----------------
  logic [THR_W-1:0] susp_thr;
  logic [THR_W-1:0] block_thr;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      susp_thr  <= SUSP_THR_RESET;
      block_thr <= BLOCK_THR_RESET;
    end else if (psel && penable && pwrite && pready) begin
      unique case (paddr[2])
        REG_SUSP_THR:  susp_thr  <= pwdata[THR_W-1:0];
        REG_BLOCK_THR: block_thr <= pwdata[THR_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_SUSP_THR:  prdata = {{(32-THR_W){1'b0}}, susp_thr};
      REG_BLOCK_THR: prdata = {{(32-THR_W){1'b0}}, block_thr};
      default:       prdata = '0;
    endcase
  end

  // ---------------- entry table ----------------
  // One write port, one registered read port; read data only moves on rd_en
  // so a stalled list scan keeps the entry under compare.
  entry_t             mem [TABLE_ENTRIES];
  entry_t             mem_q;
  logic               rd_en;
  logic [IDX_W-1:0]   rd_addr;
  logic               wr_en;
  entry_t             wr_data;
  logic [IDX_W-1:0]   slot, slot_next;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[slot] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      mem_q <= mem[rd_addr];
    end
  end

  // ---------------- sequencer state ----------------
  state_t              state, state_next;
  logic [CNT_W-1:0]    count, count_next;       // entries in use
  logic [CNT_W-1:0]    scan_idx, scan_idx_next; // next entry to read
  logic                cmp_vld, cmp_vld_next;   // mem_q holds entry cmp_idx
  logic [IDX_W-1:0]    cmp_idx, cmp_idx_next;
  logic                req_kind, req_kind_next;
  logic [ADDR_W-1:0]   req_addr, req_addr_next;
  logic                req_cred, req_cred_next;
  logic [FAIL_W-1:0]   ent_fail, ent_fail_next;
  logic                ent_blk, ent_blk_next;
  logic                pend_vld, pend_vld_next; // blocked address held back for tlast
  logic [ADDR_W-1:0]   pend_addr, pend_addr_next;
  logic [STATUS_W-1:0] res_status, res_status_next;
  logic [ADDR_W-1:0]   res_addr, res_addr_next;

  // output register load
  logic                out_load;
  logic [STATUS_W-1:0] out_status;
  logic [ADDR_W-1:0]   out_addr;
  logic                out_last;
  logic                out_busy;

  logic                rd_more;
  logic                hit;
  logic                listed;
  logic [FAIL_W-1:0]   fail_inc;

  assign out_busy = m_tvalid && !m_tready;
  assign rd_more  = (scan_idx < count);
  assign hit      = cmp_vld && (mem_q.addr == req_addr);
  assign listed   = cmp_vld && mem_q.blk;
  assign fail_inc = (ent_fail == FAIL_MAX) ? ent_fail : ent_fail + 1'b1;
  assign rd_addr  = scan_idx[IDX_W-1:0];
  assign s_tready = (state == S_IDLE);

  always_comb begin
    state_next      = state;
    count_next      = count;
    scan_idx_next   = scan_idx;
    cmp_vld_next    = cmp_vld;
    cmp_idx_next    = cmp_idx;
    req_kind_next   = req_kind;
    req_addr_next   = req_addr;
    req_cred_next   = req_cred;
    slot_next       = slot;
    ent_fail_next   = ent_fail;
    ent_blk_next    = ent_blk;
    pend_vld_next   = pend_vld;
    pend_addr_next  = pend_addr;
    res_status_next = res_status;
    res_addr_next   = res_addr;
    rd_en           = 1'b0;
    wr_en           = 1'b0;
    wr_data         = '0;
    out_load        = 1'b0;
    out_status      = '0;
    out_addr        = '0;
    out_last        = 1'b0;

    unique case (state)
      S_IDLE: begin
        if (s_tvalid) begin
          req_kind_next = s_tuser[0];
          req_addr_next = s_tdata[31:0];
          req_cred_next = s_tdata[32];
          scan_idx_next = '0;
          cmp_vld_next  = 1'b0;
          pend_vld_next = 1'b0;
          if (s_tuser[0] == KIND_LIST && !s_tdata[33]) begin
            res_status_next = ST_DENIED;
            res_addr_next   = '0;
            state_next      = S_EMIT;
          end else begin
            state_next = S_SCAN;
          end
        end
      end

      S_SCAN: begin
        if (req_kind == KIND_LOGIN) begin
          if (hit) begin
            slot_next     = cmp_idx;
            ent_fail_next = mem_q.fail;
            ent_blk_next  = mem_q.blk;
            state_next    = S_UPDATE;
          end else if (!cmp_vld && !rd_more) begin
            // new source
            if (count >= CNT_W'(TABLE_ENTRIES)) begin
              res_status_next = ST_FULL;
              res_addr_next   = '0;
              state_next      = S_EMIT;
            end else begin
              slot_next     = count[IDX_W-1:0];
              ent_fail_next = '0;
              ent_blk_next  = 1'b0;
              count_next    = count + 1'b1;
              state_next    = S_UPDATE;
            end
          end else begin
            rd_en         = rd_more;
            cmp_vld_next  = rd_more;
            cmp_idx_next  = scan_idx[IDX_W-1:0];
            scan_idx_next = scan_idx + CNT_W'(rd_more);
          end
        end else begin
          // list: hold one blocked address back so the final one carries tlast
          if (!(listed && pend_vld && out_busy)) begin
            if (listed) begin
              if (pend_vld) begin
                out_load   = 1'b1;
                out_status = ST_LISTED;
                out_addr   = pend_addr;
                out_last   = 1'b0;
              end
              pend_addr_next = mem_q.addr;
              pend_vld_next  = 1'b1;
            end
            if (!cmp_vld && !rd_more) begin
              res_status_next = pend_vld ? ST_LISTED : ST_NONE;
              res_addr_next   = pend_vld ? pend_addr : '0;
              state_next      = S_EMIT;
            end else begin
              rd_en         = rd_more;
              cmp_vld_next  = rd_more;
              cmp_idx_next  = scan_idx[IDX_W-1:0];
              scan_idx_next = scan_idx + CNT_W'(rd_more);
            end
          end
        end
      end

      S_UPDATE: begin
        wr_en        = 1'b1;
        wr_data.addr = req_addr;
        wr_data.fail = ent_fail;
        wr_data.blk  = ent_blk;
        res_addr_next = '0;
        if (ent_blk) begin
          res_status_next = ST_REFUSED;
        end else if (req_cred) begin
          wr_data.fail    = '0;
          res_status_next = ST_SUCCESS;
        end else begin
          wr_data.fail = fail_inc;
          if (fail_inc >= block_thr) begin
            wr_data.blk     = 1'b1;
            res_status_next = ST_NOW_BLOCKED;
          end else if (fail_inc >= susp_thr) begin
            res_status_next = ST_SUSPICIOUS;
          end else begin
            res_status_next = ST_FAILED;
          end
        end
        state_next = S_EMIT;
      end

      S_EMIT: begin
        if (!out_busy) begin
          out_load   = 1'b1;
          out_status = res_status;
          out_addr   = res_addr;
          out_last   = 1'b1;
          state_next = S_IDLE;
        end
      end

      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      count    <= '0;
      cmp_vld  <= 1'b0;
      pend_vld <= 1'b0;
    end else begin
      state    <= state_next;
      count    <= count_next;
      cmp_vld  <= cmp_vld_next;
      pend_vld <= pend_vld_next;
    end
  end

  always_ff @(posedge clk) begin
    scan_idx   <= scan_idx_next;
    cmp_idx    <= cmp_idx_next;
    req_kind   <= req_kind_next;
    req_addr   <= req_addr_next;
    req_cred   <= req_cred_next;
    slot       <= slot_next;
    ent_fail   <= ent_fail_next;
    ent_blk    <= ent_blk_next;
    pend_addr  <= pend_addr_next;
    res_status <= res_status_next;
    res_addr   <= res_addr_next;
  end

  // output register: parts the sequencer from the result side
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      m_tuser <= out_status;
      m_tdata <= out_addr;
      m_tlast <= out_last;
    end
  end

`ifndef SYNTH
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(TABLE_ENTRIES))
    else $error("entry count past table size");

  a_count_step: assert property (@(posedge clk) disable iff (rst)
    (count != $past(count)) |-> (count == $past(count) + 1'b1))
    else $error("entry count moved by other than one");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    out_load |-> !out_busy)
    else $error("result register loaded while held");

  a_last_single: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser != ST_LISTED) |-> (m_tlast && m_tdata == '0))
    else $error("non-list result without tlast or with address");

  a_ready_idle: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("request taken while one is in flight");
`endif

endmodule

// File: verif/failed_login_lockout_table_test.sv
`timescale 1ns / 100ps

module failed_login_lockout_table_test
  import flt_pkg::*;
;

  localparam int TABLE_SIZE  = DEF_TABLE_ENTRIES;
  localparam int DRAIN_WAIT  = TABLE_SIZE + 8;   // a little over the worst login latency
  localparam int LONG_HOLD   = 400;              // receiver hold-off, in cycles
  localparam int CYCLE_LIMIT = 1000000;

  // one login attempt or list request as the driver sends it
  typedef struct packed {
    logic              kind;
    logic [ADDR_W-1:0] src;
    logic              cred_ok;
    logic              admin;
  } attempt_t;

  // one result as the block should return it
  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [ADDR_W-1:0]   addr;
    logic                last;
  } outcome_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [39:0] s_tdata = '0;   // [31:0] source_addr, [32] credentials_valid,
                               // [33] requester_is_admin, [39:34] zero
  logic [0:0]  s_tuser = '0;   // [0] kind
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [31:0] m_tdata;        // [31:0] listed_addr
  logic [3:0]  m_tuser;        // [3:0] status
  logic        m_tlast;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  failed_login_lockout_table #(
    .TABLE_ENTRIES(TABLE_SIZE)
  ) DUT (
    .clk(clk),
    .rst(rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .s_tuser(s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata),
    .m_tuser(m_tuser),
    .m_tlast(m_tlast),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready)
  );

  always #10 clk = ~clk;

  // Shadow of the lockout table and the two thresholds.
  logic [ADDR_W-1:0] lk_addr  [TABLE_SIZE];
  logic [FAIL_W-1:0] lk_fail  [TABLE_SIZE];
  logic              lk_blk   [TABLE_SIZE];
  int                lk_count = 0;
  logic [THR_W-1:0]  lk_susp  = SUSP_THR_RESET;
  logic [THR_W-1:0]  lk_block = BLOCK_THR_RESET;

  attempt_t          attempt_queue[$];      // requests waiting for the driver
  outcome_t          expected_outcomes[$];  // results the block still owes
  logic [ADDR_W-1:0] known_src[$];          // source pool for the generator

  int   mismatches = 0;
  int   cycles = 0;
  int   results_pending = 0;  // registered copy of expected_outcomes.size()
  logic req_fire = 1'b0;      // a request was taken at the last rising edge
  int   tx_idle_pct = 0;
  int   rx_stall_pct = 0;
  logic rx_hold = 1'b0;
  event rx_hold_kick;

  task automatic flag_mismatch(input string msg);
    if (mismatches < 200) $display("mismatch at %0t: %s", $time, msg);
    mismatches++;
  endtask

  task automatic queue_outcome(input logic [STATUS_W-1:0] st, input logic [ADDR_W-1:0] a,
                               input logic l);
    outcome_t o;
    o.status = st;
    o.addr   = a;
    o.last   = l;
    expected_outcomes.push_back(o);
  endtask

  // Predictor: applies one accepted request to the shadow table and queues
  // the results it causes.
  task automatic grade_attempt(input logic kind, input logic [ADDR_W-1:0] src,
                               input logic ok, input logic admin);
    int slot;
    int i;
    int last_i;
    logic [STATUS_W-1:0] st;
    if (kind == KIND_LOGIN) begin
      slot = -1;
      for (i = 0; i < lk_count; i++)
        if (slot < 0 && lk_addr[i] == src) slot = i;
      if (slot < 0 && lk_count >= TABLE_SIZE) begin
        st = ST_FULL;   // new source, no free entry: nothing changes
      end else begin
        if (slot < 0) begin
          slot = lk_count;
          lk_addr[slot] = src;
          lk_fail[slot] = '0;
          lk_blk[slot]  = 1'b0;
          lk_count++;
        end
        if (lk_blk[slot]) begin
          st = ST_REFUSED;
        end else if (ok) begin
          lk_fail[slot] = '0;
          st = ST_SUCCESS;
        end else begin
          if (lk_fail[slot] != FAIL_MAX) lk_fail[slot] = lk_fail[slot] + 4'd1;
          // block threshold is graded first
          if (lk_fail[slot] >= lk_block) begin
            lk_blk[slot] = 1'b1;
            st = ST_NOW_BLOCKED;
          end else if (lk_fail[slot] >= lk_susp) begin
            st = ST_SUSPICIOUS;
          end else begin
            st = ST_FAILED;
          end
        end
      end
      queue_outcome(st, 32'd0, 1'b1);
    end else if (!admin) begin
      queue_outcome(ST_DENIED, 32'd0, 1'b1);
    end else begin
      last_i = -1;
      for (i = 0; i < lk_count; i++)
        if (lk_blk[i]) last_i = i;
      if (last_i < 0) begin
        queue_outcome(ST_NONE, 32'd0, 1'b1);
      end else begin
        for (i = 0; i <= last_i; i++)
          if (lk_blk[i]) queue_outcome(ST_LISTED, lk_addr[i], i == last_i);
      end
    end
  endtask

  task automatic push_req(input logic kind, input logic [ADDR_W-1:0] src,
                          input logic ok, input logic admin);
    attempt_t a;
    a.kind    = kind;
    a.src     = src;
    a.cred_ok = ok;
    a.admin   = admin;
    attempt_queue.push_back(a);
  endtask

  // Random traffic: mostly runs of failed attempts from one source, some
  // ending in a good login; the rest list requests and lone attempts.
  // New sources join the pool only while it is below pool_lim.
  task automatic run_traffic(input int n, input int pool_lim, input int new_pct);
    int made;
    int pick;
    int run;
    logic [ADDR_W-1:0] who;
    made = 0;
    while (made < n) begin
      pick = $urandom_range(99);
      if (pick < 8) begin
        push_req(KIND_LIST, $urandom, 1'($urandom_range(1)), $urandom_range(99) < 85);
        made++;
      end else if (pick < 18) begin
        push_req(KIND_LOGIN, known_src[$urandom_range(known_src.size() - 1)],
                 1'($urandom_range(1)), 1'($urandom_range(1)));
        made++;
      end else begin
        if (known_src.size() < pool_lim && $urandom_range(99) < new_pct) begin
          who = $urandom;
          known_src.push_back(who);
        end else begin
          who = known_src[$urandom_range(known_src.size() - 1)];
        end
        run = $urandom_range(lk_block + 1, 1);
        repeat (run) push_req(KIND_LOGIN, who, 1'b0, 1'($urandom_range(1)));
        made += run;
        if ($urandom_range(99) < 45) begin
          push_req(KIND_LOGIN, who, 1'b1, 1'($urandom_range(1)));
          made++;
        end
      end
    end
  endtask

  // Sender pause: no request queued or offered and no result owed, then
  // a margin for the scan to settle.
  task automatic wait_idle();
    while (attempt_queue.size() != 0 || s_tvalid || results_pending != 0)
      @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  task automatic csr_expect(input logic idx);
    logic [31:0] want;
    want = {28'd0, (idx == REG_SUSP_THR) ? lk_susp : lk_block};
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= {idx, 2'b00};
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    if (prdata !== want)
      flag_mismatch($sformatf("register %0d reads %0h, want %0h", idx, prdata, want));
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  // Only called with the block idle; the register keeps the low 4 bits.
  task automatic set_threshold(input logic idx, input logic [31:0] value);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (idx == REG_SUSP_THR) lk_susp = value[THR_W-1:0];
    else lk_block = value[THR_W-1:0];
    csr_expect(idx);
  endtask

  // Driver: offers the next queued request, or idles, once the current one
  // has been taken. tvalid only changes here, once per falling edge.
  always @(negedge clk) begin : drive_requests
    attempt_t nxt;
    if (!s_tvalid || req_fire) begin
      if (attempt_queue.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
        nxt = attempt_queue.pop_front();
        s_tvalid <= 1'b1;
        s_tdata  <= {6'd0, nxt.admin, nxt.cred_ok, nxt.src};
        s_tuser  <= nxt.kind;
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // Result side: random stalls, or held low for a long stretch on request.
  always @(negedge clk) begin
    if (rx_hold) m_tready <= 1'b0;
    else m_tready <= ($urandom_range(99) >= rx_stall_pct);
  end

  always begin
    @(rx_hold_kick);
    rx_hold = 1'b1;
    repeat (LONG_HOLD) @(posedge clk);
    rx_hold = 1'b0;
  end

  // Monitor: predicts on every accepted request, checks every accepted
  // result against the oldest expectation, and watches the cycle budget.
  always @(posedge clk) begin : watch_streams
    outcome_t want;
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
    if (rst) begin
      req_fire <= 1'b0;
    end else begin
      req_fire <= s_tvalid && s_tready;
      if (s_tvalid && s_tready)
        grade_attempt(s_tuser[0], s_tdata[31:0], s_tdata[32], s_tdata[33]);
      if (m_tvalid && m_tready) begin
        if (expected_outcomes.size() == 0) begin
          flag_mismatch($sformatf("unexpected result status %0d addr %0h", m_tuser, m_tdata));
        end else begin
          want = expected_outcomes.pop_front();
          if (m_tuser !== want.status)
            flag_mismatch($sformatf("status %0d, want %0d", m_tuser, want.status));
          if (m_tdata !== want.addr)
            flag_mismatch($sformatf("listed_addr %0h, want %0h", m_tdata, want.addr));
          if (m_tlast !== want.last)
            flag_mismatch($sformatf("last %0b, want %0b", m_tlast, want.last));
        end
      end
      results_pending <= expected_outcomes.size();
    end
  end

  initial begin
    repeat (2) @(negedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // thresholds come up at their reset values
    csr_expect(REG_SUSP_THR);
    csr_expect(REG_BLOCK_THR);

    // Directed: empty list, non-admin list, new source with a good login,
    // one source failing up to the block threshold and past it, list of
    // the blocked source, count cleared by a good login. Ignored fields
    // are driven to their extremes.
    known_src.push_back(32'h0000_0000);
    known_src.push_back(32'hFFFF_FFFF);
    push_req(KIND_LIST, 32'hFFFF_FFFF, 1'b1, 1'b1);
    push_req(KIND_LIST, 32'h0000_0000, 1'b0, 1'b0);
    push_req(KIND_LOGIN, 32'h0000_0000, 1'b1, 1'b1);
    repeat (10) push_req(KIND_LOGIN, 32'hFFFF_FFFF, 1'b0, 1'b0);
    push_req(KIND_LOGIN, 32'hFFFF_FFFF, 1'b0, 1'b1);
    push_req(KIND_LOGIN, 32'hFFFF_FFFF, 1'b1, 1'b0);
    push_req(KIND_LIST, 32'h0000_0000, 1'b0, 1'b1);
    push_req(KIND_LIST, 32'hFFFF_FFFF, 1'b1, 1'b0);
    push_req(KIND_LOGIN, 32'h0000_0000, 1'b0, 1'b1);
    push_req(KIND_LOGIN, 32'h0000_0000, 1'b1, 1'b0);
    push_req(KIND_LOGIN, 32'h0000_0000, 1'b0, 1'b0);
    wait_idle();

    // lowest suspicious, highest block threshold, no idling
    set_threshold(REG_SUSP_THR, 32'd1);
    set_threshold(REG_BLOCK_THR, 32'd15);
    run_traffic(90, 16, 30);
    wait_idle();

    // the reverse, sender mostly idle
    tx_idle_pct = 81;
    set_threshold(REG_SUSP_THR, 32'd15);
    set_threshold(REG_BLOCK_THR, 32'd1);
    run_traffic(80, 24, 30);
    wait_idle();

    // equal thresholds: block has to win; receiver stalls, and one long
    // hold-off while the sender keeps offering so the input backs up
    tx_idle_pct  = 0;
    rx_stall_pct = 81;
    set_threshold(REG_SUSP_THR, 32'd3);
    set_threshold(REG_BLOCK_THR, 32'd3);
    run_traffic(90, 32, 30);
    -> rx_hold_kick;
    wait_idle();

    // wide writes keep the low bits only: block threshold of zero, so
    // every failure blocks at once
    tx_idle_pct  = 17;
    rx_stall_pct = 17;
    set_threshold(REG_SUSP_THR, 32'hFFFF_FFF7);
    set_threshold(REG_BLOCK_THR, 32'h0000_0010);
    run_traffic(30, 36, 40);
    wait_idle();

    // fill the table past its size: later new sources see table full
    set_threshold(REG_SUSP_THR, 32'd4);
    set_threshold(REG_BLOCK_THR, 32'd8);
    while (known_src.size() < TABLE_SIZE + 6) begin
      known_src.push_back($urandom);
      push_req(KIND_LOGIN, known_src[known_src.size() - 1], 1'b1, 1'($urandom_range(1)));
    end
    run_traffic(60, TABLE_SIZE + 24, 50);
    wait_idle();

    // full table, mid thresholds, no idling
    tx_idle_pct  = 0;
    rx_stall_pct = 0;
    set_threshold(REG_SUSP_THR, 32'd6);
    set_threshold(REG_BLOCK_THR, 32'd12);
    run_traffic(90, TABLE_SIZE + 30, 15);
    wait_idle();

    if (results_pending != 0) flag_mismatch("results still owed at end of run");
    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
